### rtl/core/ctb_pkg.sv
`default_nettype none

package ctb_pkg;

  // field and register widths
  localparam int SHARE_W = 11;
  localparam int SLICE_W = 30;
  localparam int TIME_W  = 64;
  localparam int AMT_W   = 40;
  localparam int LEVEL_W = 33;
  localparam int GAIN_W  = 33;
  localparam int KIND_W  = 2;
  localparam int CFG_IDX_W = 1;

  // digit-serial datapath
  localparam int DIGIT_W = 4;
  localparam int BURST_W = SLICE_W + 2;
  localparam int SPACE_W = SLICE_W - 2;
  localparam int TOK_W   = 36;                 // sign-extended token store
  localparam int MUL_W   = SHARE_W + DIGIT_W;
  localparam int SCALE_SH = 10;                // x1024
  localparam int HIST_W  = ((SCALE_SH + DIGIT_W - 1) / DIGIT_W) * DIGIT_W;
  localparam int WIN_OFF = HIST_W - SCALE_SH;

  localparam int REFILL_DIGITS = 76 / DIGIT_W; // elapsed*share + share vs room*1024
  localparam int MOVE_DIGITS   = 44 / DIGIT_W; // tokens +/- amount with clamp
  localparam int TIME_DIGITS   = TIME_W / DIGIT_W;
  localparam int TOK_DIGITS    = TOK_W / DIGIT_W;
  localparam int GAIN_FIRST    = HIST_W / DIGIT_W;
  localparam int GAIN_LAST     = GAIN_FIRST + TOK_DIGITS - 1;
  localparam int CNT_W         = $clog2(REFILL_DIGITS);

  localparam logic [SHARE_W-1:0] SHARE_ONE   = SHARE_W'(1024);
  localparam logic [SLICE_W-1:0] RESET_SLICE = SLICE_W'(20000000);

  localparam logic [KIND_W-1:0] KIND_REFILL = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CHARGE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_BUDGET = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLICE  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REFILL,
    ST_MOVE,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

### rtl/core/credit_token_bucket_top.sv
`default_nettype none

// Channel  Direction  Handshake            Payload
// input    in         in_valid / in_stall  kind, now_time, charge_amount
// output   out        out_valid / out_stall token_level, can_lend, refill_gain
// config   in         cfg_write            cfg_index, cfg_data
//
// One item at a time, 4-bit digits per cycle. A refill that earns tokens runs an
// elapsed/multiply/compare pass, then a token update pass, then loads the result; a
// refill that earns nothing skips the update pass, a charge runs only the update pass
// (none when unlimited), and a query loads the result directly.
// Synchronous active-high reset: empty bucket, never refilled, default slice.
// in_stall is high while an item is in work; a finished result waits in the
// output register while out_stall is high, and the next item may enter then.

module credit_token_bucket_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [ctb_pkg::KIND_W-1:0]        kind,
  input  logic [ctb_pkg::TIME_W-1:0]        now_time,
  input  logic [ctb_pkg::AMT_W-1:0]         charge_amount,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [ctb_pkg::LEVEL_W-1:0] token_level,
  output logic                              can_lend,
  output logic [ctb_pkg::GAIN_W-1:0]        refill_gain,
  input  logic                              cfg_write,
  input  logic [ctb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ctb_pkg::SLICE_W-1:0]       cfg_data
);

  import ctb_pkg::*;

  function automatic logic [DIGIT_W:0] dadd(input logic [DIGIT_W-1:0] a,
                                            input logic [DIGIT_W-1:0] b,
                                            input logic ci);
    dadd = {1'b0, a} + {1'b0, b} + {{DIGIT_W{1'b0}}, ci};
  endfunction

  function automatic logic [DIGIT_W:0] dsub(input logic [DIGIT_W-1:0] a,
                                            input logic [DIGIT_W-1:0] b,
                                            input logic bi);
    dsub = {1'b0, a} - {1'b0, b} - {{DIGIT_W{1'b0}}, bi};
  endfunction

  state_t state, state_next;
  logic [CNT_W-1:0] cnt;

  // configuration and bucket state
  logic [SHARE_W-1:0] budget_share;
  logic [SLICE_W-1:0] slice_length;
  logic [TOK_W-1:0]   tokens;
  logic [TIME_W-1:0]  last_refill_time;
  logic               never_q;
  logic               tok_pos;
  logic [GAIN_W-1:0]  gain_q;

  // working shift registers
  logic [TIME_W-1:0]   now_sr;
  logic [SPACE_W-1:0]  sp_sr;
  logic [DIGIT_W*3-1:0] bs_sr;
  logic [BURST_W-1:0]  bu_sr;
  logic [AMT_W-1:0]    amt_sr;
  logic [SHARE_W-1:0]  acc;
  logic [HIST_W-1:0]   hist_r, hist_p;
  logic [TOK_W-1:0]    room_sr, pg_sr, v_sr, nb_sr;
  logic eb, sb, cx, rb, rx, esign, now_nz, room_nz, pg_nz;
  logic vc, ob, uc, nbb, v_nz, bu_nz, amt_nz, sub_q;

  logic in_take, out_free, out_load;
  logic time_act, tok_act, p1_last, p2_last;
  logic start_refill, start_move;
  logic [BURST_W-1:0] burst;

  logic [DIGIT_W:0] e_t, s_t, x_t, r_t, c_t;
  logic [DIGIT_W:0] va_t, vs_t, v_t, o_t, u_t, n_t;
  logic [DIGIT_W-1:0] e_d, p_d, r_d, rr_d, g_d, tok_d, v_d;
  logic [MUL_W-1:0] prod;
  logic [HIST_W+DIGIT_W-1:0] rcur, pcur;
  logic lt, room_pos, use_room, refill_ok, apply, over, under, v_pos, commit;
  logic [GAIN_W-1:0] gain_val;
  logic unlimited;

  assign burst     = {slice_length, 2'b00};
  assign unlimited = budget_share >= SHARE_ONE;
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign time_act  = cnt < CNT_W'(TIME_DIGITS);
  assign tok_act   = cnt < CNT_W'(TOK_DIGITS);
  assign p1_last   = (state == ST_REFILL) && (cnt == CNT_W'(REFILL_DIGITS - 1));
  assign p2_last   = (state == ST_MOVE) && (cnt == CNT_W'(MOVE_DIGITS - 1));

  assign tok_d = tok_act ? tokens[DIGIT_W-1:0] : {DIGIT_W{tokens[TOK_W-1]}};

  // refill pass: elapsed, spacing compare, elapsed*share, room*1024 compare
  always_comb begin
    e_t  = dsub(now_sr[DIGIT_W-1:0], last_refill_time[DIGIT_W-1:0], eb);
    e_d  = time_act ? e_t[DIGIT_W-1:0] : '0;
    s_t  = dsub(e_d, sp_sr[DIGIT_W-1:0], sb);
    prod = {{DIGIT_W{1'b0}}, acc} + (MUL_W'(e_d) * MUL_W'(budget_share));
    p_d  = prod[DIGIT_W-1:0];
    x_t  = dadd(p_d, bs_sr[DIGIT_W-1:0], cx);
    r_t  = dsub(bu_sr[DIGIT_W-1:0], tok_d, rb);
    r_d  = r_t[DIGIT_W-1:0];
    rcur = {r_d, hist_r};
    rr_d = rcur[WIN_OFF +: DIGIT_W];     // room delayed by the x1024 shift
    pcur = {p_d, hist_p};
    g_d  = pcur[SCALE_SH +: DIGIT_W];    // product advanced by the /1024 shift
    c_t  = dsub(rr_d, x_t[DIGIT_W-1:0], rx);

    lt        = s_t[DIGIT_W];
    room_pos  = !r_d[DIGIT_W-1] && (room_nz || (r_d != '0));
    use_room  = c_t[DIGIT_W];            // elapsed*share + share > room*1024
    refill_ok = !esign && !lt;
    apply     = refill_ok && (budget_share != '0) && room_pos && (use_room || pg_nz);
    gain_val  = use_room ? room_sr[GAIN_W-1:0] : pg_sr[GAIN_W-1:0];
  end

  // move pass: v = tokens +/- amount, clamp to [-burst, burst]
  always_comb begin
    va_t   = dadd(tok_d, amt_sr[DIGIT_W-1:0], vc);
    vs_t   = dsub(tok_d, amt_sr[DIGIT_W-1:0], vc);
    v_t    = sub_q ? vs_t : va_t;
    v_d    = v_t[DIGIT_W-1:0];
    o_t    = dsub(bu_sr[DIGIT_W-1:0], v_d, ob);
    u_t    = dadd(v_d, bu_sr[DIGIT_W-1:0], uc);
    n_t    = dsub(DIGIT_W'(0), bu_sr[DIGIT_W-1:0], nbb);
    over   = o_t[DIGIT_W-1];
    under  = u_t[DIGIT_W-1];
    v_pos  = !v_d[DIGIT_W-1] && (v_nz || (v_d != '0));
    commit = (amt_nz || (amt_sr[DIGIT_W-1:0] != '0)) && (!sub_q || !unlimited);
  end

  assign start_refill = in_take && (kind == KIND_REFILL);
  assign start_move   = (in_take && (kind == KIND_CHARGE) && !unlimited) ||
                        (p1_last && apply);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_take) begin
          case (kind)
            KIND_REFILL: state_next = ST_REFILL;
            KIND_CHARGE: state_next = unlimited ? ST_FINISH : ST_MOVE;
            KIND_QUERY:  state_next = ST_FINISH;
            default:     state_next = ST_FINISH;
          endcase
        end
      end
      ST_REFILL: begin
        if (p1_last) state_next = apply ? ST_MOVE : ST_FINISH;
      end
      ST_MOVE: begin
        if (p2_last) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_stall = (state != ST_IDLE);
    out_load = (state == ST_FINISH) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      cnt              <= '0;
      out_valid        <= 1'b0;
      budget_share     <= '0;
      slice_length     <= RESET_SLICE;
      tokens           <= '0;
      last_refill_time <= '0;
      never_q          <= 1'b1;
      tok_pos          <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= (state_next != state) ? '0 : cnt + CNT_W'(1);

      if (out_load) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;

      if (cfg_write) begin
        case (cfg_index)
          CFG_BUDGET: budget_share <= cfg_data[SHARE_W-1:0];
          CFG_SLICE:  slice_length <= cfg_data;
          default: ;
        endcase
      end

      // both passes rotate the stored words once and leave them in place
      if (state == ST_REFILL && time_act)
        last_refill_time <= {last_refill_time[DIGIT_W-1:0],
                             last_refill_time[TIME_W-1:DIGIT_W]};
      if (p1_last && refill_ok) begin
        last_refill_time <= now_sr;
        never_q          <= !now_nz;
      end

      if ((state == ST_REFILL || state == ST_MOVE) && tok_act)
        tokens <= {tokens[DIGIT_W-1:0], tokens[TOK_W-1:DIGIT_W]};
      if (p2_last && commit) begin
        if (over) begin
          tokens  <= TOK_W'(burst);
          tok_pos <= bu_nz;
        end else if (under) begin
          tokens  <= nb_sr;
          tok_pos <= 1'b0;
        end else begin
          tokens  <= v_sr;
          tok_pos <= v_pos;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_take) gain_q <= '0;
    if (p1_last && apply) gain_q <= gain_val;

    if (start_refill) begin
      now_sr  <= now_time;
      sp_sr   <= slice_length[SLICE_W-1:2];
      bs_sr   <= {{(DIGIT_W*3-SHARE_W){1'b0}}, budget_share};
      bu_sr   <= burst;
      acc     <= '0;
      hist_r  <= '0;
      hist_p  <= '0;
      eb      <= 1'b0;
      sb      <= 1'b0;
      cx      <= 1'b0;
      rb      <= 1'b0;
      rx      <= 1'b0;
      esign   <= 1'b0;
      now_nz  <= 1'b0;
      room_nz <= 1'b0;
      pg_nz   <= 1'b0;
    end else if (state == ST_REFILL) begin
      if (time_act) begin
        now_sr <= {now_sr[DIGIT_W-1:0], now_sr[TIME_W-1:DIGIT_W]};
        if (now_sr[DIGIT_W-1:0] != '0) now_nz <= 1'b1;
      end
      if (cnt == CNT_W'(TIME_DIGITS - 1)) esign <= e_t[DIGIT_W-1];
      sp_sr  <= {{DIGIT_W{1'b0}}, sp_sr[SPACE_W-1:DIGIT_W]};
      bs_sr  <= {{DIGIT_W{1'b0}}, bs_sr[DIGIT_W*3-1:DIGIT_W]};
      // the move pass reloads the burst when it starts
      if (!start_move) bu_sr <= {{DIGIT_W{1'b0}}, bu_sr[BURST_W-1:DIGIT_W]};
      acc    <= prod[MUL_W-1:DIGIT_W];
      hist_r <= rcur[HIST_W+DIGIT_W-1:DIGIT_W];
      hist_p <= pcur[HIST_W+DIGIT_W-1:DIGIT_W];
      eb     <= e_t[DIGIT_W];
      sb     <= s_t[DIGIT_W];
      cx     <= x_t[DIGIT_W];
      rb     <= r_t[DIGIT_W];
      rx     <= c_t[DIGIT_W];
      if (r_d != '0) room_nz <= 1'b1;
      if (tok_act) room_sr <= {r_d, room_sr[TOK_W-1:DIGIT_W]};
      if (cnt >= CNT_W'(GAIN_FIRST) && cnt <= CNT_W'(GAIN_LAST)) begin
        pg_sr <= {g_d, pg_sr[TOK_W-1:DIGIT_W]};
        if (g_d != '0) pg_nz <= 1'b1;
      end
    end

    if (start_move) begin
      amt_sr <= in_take ? charge_amount : AMT_W'(gain_val);
      sub_q  <= in_take;
      bu_sr  <= burst;
      vc     <= 1'b0;
      ob     <= 1'b0;
      uc     <= 1'b0;
      nbb    <= 1'b0;
      v_nz   <= 1'b0;
      bu_nz  <= 1'b0;
      amt_nz <= 1'b0;
    end else if (state == ST_MOVE) begin
      amt_sr <= {{DIGIT_W{1'b0}}, amt_sr[AMT_W-1:DIGIT_W]};
      bu_sr  <= {{DIGIT_W{1'b0}}, bu_sr[BURST_W-1:DIGIT_W]};
      vc     <= v_t[DIGIT_W];
      ob     <= o_t[DIGIT_W];
      uc     <= u_t[DIGIT_W];
      nbb    <= n_t[DIGIT_W];
      if (v_d != '0) v_nz <= 1'b1;
      if (bu_sr[DIGIT_W-1:0] != '0) bu_nz <= 1'b1;
      if (amt_sr[DIGIT_W-1:0] != '0) amt_nz <= 1'b1;
      if (tok_act) begin
        v_sr  <= {v_d, v_sr[TOK_W-1:DIGIT_W]};
        nb_sr <= {n_t[DIGIT_W-1:0], nb_sr[TOK_W-1:DIGIT_W]};
      end
    end

    if (out_load) begin
      token_level <= tokens[LEVEL_W-1:0];
      refill_gain <= gain_q;
      can_lend    <= unlimited || ((budget_share != '0) && (never_q || tok_pos));
    end
  end

endmodule

`default_nettype wire
